/* hdl/bss_pkg.sv */
package bss_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int PAT_BYTES       = 16;
    localparam int LEN_W           = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int WORD_W          = 32;

    localparam logic [7:0]        JMP_OPCODE = 8'hE9;
    localparam logic [WORD_W-1:0] JMP_LEN    = 32'd5;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RESULT_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 3'd4;

    localparam logic [1:0] MODE_OFFSET = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_JUMP   = 2'd2;

    localparam logic [1:0] ST_NOT_FOUND = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_NO_JUMP   = 2'd3;

    typedef enum logic [3:0] {
        PH_SEARCH  = 4'b0001,
        PH_CAPTURE = 4'b0010,
        PH_FOUND   = 4'b0100,
        PH_NOJMP   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       fire;
        logic       last;
        logic [7:0] data;
    } t_step;

    typedef struct packed {
        logic [1:0]        status;
        logic [WORD_W-1:0] value;
    } t_result;

endpackage

/* hdl/byte_signature_scanner.sv */
// The result of a stream is registered in the result register when the last item leaves the input register.
// Throughput: one item per cycle while no last item waits; the window compare and tracking
// logic sit between the input register and the result register and process each byte there.
// A last item waits in the input register while the previous result has not been taken.
// Reset is synchronous and active low; it clears the stream state, the handshake
// registers and sets the configuration registers to their documented defaults.
module byte_signature_scanner
    import bss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // data_byte [7:0]
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [WORD_W-1:0]     o_m_axis_tdata,   // value [31:0]
    output logic [1:0]            o_m_axis_tuser,   // status [1:0]
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [63:0]       r_pat_low;
    logic [63:0]       r_pat_high;
    logic [LEN_W-1:0]  r_pat_len;
    logic [1:0]        r_mode;
    logic [WORD_W-1:0] r_base;

    logic              r_in_valid;
    logic [7:0]        r_in_data;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out;

    logic              proc_fire;
    logic [LEN_W-1:0]  eff_len;
    logic              hit;
    logic              searching;
    t_step             step;
    t_result           result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= LEN_W'(1);
            r_mode     <= MODE_OFFSET;
            r_base     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_PATTERN_LOW:    r_pat_low  <= i_cfg_wdata;
                REG_PATTERN_HIGH:   r_pat_high <= i_cfg_wdata;
                REG_PATTERN_LENGTH: r_pat_len  <= i_cfg_wdata[LEN_W-1:0];
                REG_RESULT_MODE:    r_mode     <= i_cfg_wdata[1:0];
                REG_BASE_ADDRESS:   r_base     <= i_cfg_wdata[WORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_pat_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = r_pat_len;
        end
    end

    assign proc_fire       = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proc_fire;

    assign step = {proc_fire, r_in_last, r_in_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_data <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    bss_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .i_clk       (i_clk),
        .i_step      (step),
        .i_searching (searching),
        .i_len       (eff_len),
        .i_pattern   ({r_pat_high, r_pat_low}),
        .o_hit       (hit)
    );

    bss_track u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_hit       (hit),
        .i_len       (eff_len),
        .i_mode      (r_mode),
        .i_base      (r_base),
        .o_searching (searching),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.value;
    assign o_m_axis_tuser  = r_out.status;

endmodule

/* hdl/bss_window.sv */
module bss_window
    import bss_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                    i_clk,
    input  t_step                   i_step,
    input  logic                    i_searching,
    input  logic [LEN_W-1:0]        i_len,
    input  logic [PAT_BYTES*8-1:0]  i_pattern,
    output logic                    o_hit
);

    logic [7:0] r_win [MAX_PATTERN];
    logic [7:0] win_new [MAX_PATTERN];
    logic [7:0] pat [PAT_BYTES];

    always_comb begin
        for (int k = 0; k < PAT_BYTES; k++) begin
            pat[k] = i_pattern[8*k +: 8];
        end
        win_new[0] = i_step.data;
        for (int j = 1; j < MAX_PATTERN; j++) begin
            win_new[j] = r_win[j-1];
        end
    end

    always_comb begin
        logic [LEN_W-1:0] idx;
        o_hit = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            idx = i_len - LEN_W'(1) - LEN_W'(j);
            if (LEN_W'(j) < i_len && win_new[j] != pat[idx[3:0]]) begin
                o_hit = 1'b0;
            end
        end
    end

    // Entries are only compared once the stream offset covers them, so no clear is needed.
    always_ff @(posedge i_clk) begin
        if (i_step.fire && i_searching) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= win_new[j];
            end
        end
    end

endmodule

/* hdl/bss_track.sv */
module bss_track
    import bss_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_step             i_step,
    input  logic              i_hit,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [1:0]        i_mode,
    input  logic [WORD_W-1:0] i_base,
    output logic              o_searching,
    output t_result           o_result
);

    t_phase            r_phase, n_phase;
    logic [WORD_W-1:0] r_offset, n_offset;
    logic [2:0]        r_count, n_count;
    logic [WORD_W-1:0] r_word, n_word;
    logic [WORD_W-1:0] r_match_end, n_match_end;
    logic [1:0]        mode;

    assign o_searching = (r_phase == PH_SEARCH);
    assign mode        = (i_mode > MODE_JUMP) ? MODE_OFFSET : i_mode;

    always_comb begin
        logic [2:0] need;
        n_phase     = r_phase;
        n_count     = r_count;
        n_word      = r_word;
        n_match_end = r_match_end;
        n_offset    = (r_offset == '1) ? r_offset : r_offset + WORD_W'(1);
        need        = (mode == MODE_JUMP) ? 3'd5 : 3'd4;
        unique case (r_phase)
            PH_SEARCH: begin
                if (i_hit && n_offset >= WORD_W'(i_len)) begin
                    n_match_end = n_offset;
                    n_count     = 3'd0;
                    n_word      = '0;
                    n_phase     = (mode == MODE_OFFSET) ? PH_FOUND : PH_CAPTURE;
                end
            end
            PH_CAPTURE: begin
                if (mode == MODE_OFFSET) begin
                    n_phase = PH_FOUND;
                end else if (mode == MODE_JUMP && r_count == 3'd0) begin
                    if (i_step.data == JMP_OPCODE) begin
                        n_count = 3'd1;
                    end else begin
                        n_phase = PH_NOJMP;
                    end
                end else begin
                    n_word  = {i_step.data, r_word[WORD_W-1:8]};
                    n_count = r_count + 3'd1;
                    if (n_count >= need) begin
                        n_phase = PH_FOUND;
                    end
                end
            end
            PH_FOUND, PH_NOJMP: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result = '0;
        unique case (n_phase)
            PH_FOUND: begin
                o_result.status = ST_FOUND;
                if (mode == MODE_OFFSET) begin
                    o_result.value = n_match_end;
                end else if (mode == MODE_WORD) begin
                    o_result.value = n_word;
                end else begin
                    o_result.value = i_base + n_match_end + n_word + JMP_LEN;
                end
            end
            PH_CAPTURE: o_result.status = ST_TRUNCATED;
            PH_NOJMP:   o_result.status = ST_NO_JUMP;
            PH_SEARCH:  o_result.status = ST_NOT_FOUND;
            default:    o_result.status = ST_NOT_FOUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEARCH;
            r_offset    <= '0;
            r_count     <= '0;
            r_word      <= '0;
            r_match_end <= '0;
        end else if (i_step.fire) begin
            if (i_step.last) begin
                r_phase     <= PH_SEARCH;
                r_offset    <= '0;
                r_count     <= '0;
                r_word      <= '0;
                r_match_end <= '0;
            end else begin
                r_phase     <= n_phase;
                r_offset    <= n_offset;
                r_count     <= n_count;
                r_word      <= n_word;
                r_match_end <= n_match_end;
            end
        end
    end

endmodule
